// File: rtl/core/rbf_pkg.sv
// Types and constants shared by the RGB 3x3 box filter modules.
`timescale 1ns / 1ps
package rbf_pkg;

	localparam int DIM_W   = 11;
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 3;
	localparam int PIX_W   = NUM_CH * CH_W;
	localparam int COL_W   = CH_W + 2;
	localparam int PAIR_W  = CH_W + 3;
	localparam int SUM_W   = CH_W + 4;
	localparam int RECIP_W = 13;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int RECIP_SH = 16;

	// ceil(2^16 / 9); exact floor(x / 9) for x below 32768
	localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	localparam logic CMD_DRAIN = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

	typedef struct packed {
		logic drop;
		logic zero_pix;
		logic has_result;
		logic inner;
		logic last_px;
	} ctrl_t;

endpackage

// File: rtl/core/rbf_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module rbf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read during write to the same entry returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/rbf_ctrl.sv
// Raster counters, frame tracking and per-word decisions of the box filter.
`timescale 1ns / 1ps
module rbf_ctrl
	import rbf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         cmd,
	input  logic [DIM_W-1:0]             image_width,
	input  logic [DIM_W-1:0]             image_height,
	output ctrl_t                        item,
	output logic [$clog2(MAX_WIDTH)-1:0] addr
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT) + 2;
	localparam int XW = ((RW > DIM_W) ? RW : DIM_W) + 2;

	logic [CW-1:0] icol_q, ocol_q, icol_n, ocol_n;
	logic [RW-1:0] irow_q, orow_q, irow_n, orow_n, irow_inc, orow_inc;
	logic          frame_done_q, frame_done_n;

	logic [DIM_W-1:0] w, h;
	logic [XW-1:0]    wx, hx, icx, irx, ocx, orx, icol_inc, ocol_inc;
	logic             drop, has_res, inner, last_px;

	always_comb begin
		if (image_width == '0) begin
			w = DIM_W'(1);
		end else if (int'(image_width) > MAX_WIDTH) begin
			w = DIM_W'(MAX_WIDTH);
		end else begin
			w = image_width;
		end
		if (image_height == '0) begin
			h = DIM_W'(1);
		end else if (int'(image_height) > MAX_HEIGHT) begin
			h = DIM_W'(MAX_HEIGHT);
		end else begin
			h = image_height;
		end
	end

	assign wx = XW'(w);
	assign hx = XW'(h);
	assign icx = XW'(icol_q);
	assign irx = XW'(irow_q);
	assign ocx = XW'(ocol_q);
	assign orx = XW'(orow_q);
	assign icol_inc = icx + XW'(1);
	assign ocol_inc = ocx + XW'(1);

	// rows saturate above any legal height
	assign irow_inc = (irow_q == '1) ? irow_q : irow_q + RW'(1);
	assign orow_inc = (orow_q == '1) ? orow_q : orow_q + RW'(1);

	assign drop = !frame_done_q && (cmd == CMD_DRAIN);

	// raster position of this word is at least width+1
	assign has_res = (irx >= XW'(2)) || ((irx == XW'(1)) && (icx != '0))
		|| ((irx == '0) && (icx >= wx + XW'(1)));

	assign inner = (wx >= XW'(3)) && (hx >= XW'(3))
		&& (orx >= XW'(1)) && (orx + XW'(2) <= hx)
		&& (ocx >= XW'(1)) && (ocx + XW'(2) <= wx);

	assign last_px = (orx + XW'(1) >= hx) && (ocx + XW'(1) >= wx);

	always_comb begin
		item.drop       = drop;
		item.zero_pix   = frame_done_q;
		item.has_result = has_res && !drop;
		item.inner      = inner;
		item.last_px    = last_px;
	end

	assign addr = icol_q;

	always_comb begin
		icol_n = icol_q;
		irow_n = irow_q;
		ocol_n = ocol_q;
		orow_n = orow_q;
		frame_done_n = frame_done_q;
		if (accept && !drop) begin
			if (icol_inc >= wx) begin
				icol_n = '0;
				irow_n = irow_inc;
				if (XW'(irow_inc) >= hx) begin
					frame_done_n = 1'b1;
				end
			end else begin
				icol_n = icol_inc[CW-1:0];
			end
			if (has_res) begin
				if (last_px) begin
					icol_n = '0;
					irow_n = '0;
					ocol_n = '0;
					orow_n = '0;
					frame_done_n = 1'b0;
				end else if (ocol_inc >= wx) begin
					ocol_n = '0;
					orow_n = orow_inc;
				end else begin
					ocol_n = ocol_inc[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			frame_done_q <= 1'b0;
		end else begin
			icol_q <= icol_n;
			irow_q <= irow_n;
			ocol_q <= ocol_n;
			orow_q <= orow_n;
			frame_done_q <= frame_done_n;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.has_result && item.last_px |=>
		(icol_q == '0) && (irow_q == '0) && (ocol_q == '0) && (orow_q == '0) && !frame_done_q)
		else $error("end of frame did not clear counters");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frame_done_q) |-> $past(accept && !drop))
		else $error("frame done set without a pixel word");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(icol_q) < MAX_WIDTH) && (int'(ocol_q) < MAX_WIDTH))
		else $error("column counter beyond row store");

endmodule

// File: rtl/core/rgb_box_filter_3x3.sv
// Top level of the streaming RGB 3x3 box filter with APB register port.
// Accepts one word per clock while the output does not stall. Each accepted
// pixel reads its column of the two row stores (one MAX_WIDTH x 48 RAM,
// registered read) and writes it back as stage 1 moves on; a back-to-back hit
// on the same entry is forwarded. A result passes stages 1 and 2 and the output
// register after the word that causes it, image_width+1 pixels after its
// pixel; drain words (tuser high) push out the tail of a frame. The row
// store needs no clearing pass after reset. Registers: image_width at 0x0,
// image_height at 0x4, both 11 bits, written only between words by the user.
`timescale 1ns / 1ps
module rgb_box_filter_3x3
	import rbf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
	input  logic        s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red_out, green_out, blue_out
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [DIM_W-1:0] image_width_q, image_height_q;

	ctrl_t         item;
	logic [CW-1:0] rd_addr;
	logic          s_acc, load1;
	logic          out_free, ready1, ready2, fire1, fire2;

	logic          v1_s1, res_s1, inner_s1, last_s1, fwd_s1;
	logic [CW-1:0] addr_s1;
	pix_t          pix_s1, fwd_up_s1, fwd_mid_s1;

	logic                        v2_s2, inner_s2, last_s2;
	logic [NUM_CH-1:0][SUM_W-1:0] sum_s2;
	pix_t                        ctr_s2;

	logic [NUM_CH-1:0][PAIR_W-1:0] pair_q;
	logic [NUM_CH-1:0][COL_W-1:0]  csb_q, cs_new;
	pix_t                          midb_q;

	logic [2*PIX_W-1:0]            ram_rdata;
	pix_t                          pix_in, up, mid, mean, out_pix;
	logic [NUM_CH-1:0][PROD_W-1:0] prod;

	logic          m_valid_q, m_last_q;
	pix_t          m_pix_q;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(640);
			image_height_q <= DIM_W'(480);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_WIDTH: image_width_q <= pwdata[DIM_W-1:0];
				default:   image_height_q <= pwdata[DIM_W-1:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH: prdata = 32'(image_width_q);
			default:   prdata = 32'(image_height_q);
		endcase
	end

	// pipeline handshake
	assign out_free = !m_valid_q || m_axis_tready;
	assign ready2   = !v2_s2 || out_free;
	assign fire2    = v2_s2 && out_free;
	assign ready1   = !v1_s1 || ready2;
	assign fire1    = v1_s1 && ready2;
	assign s_axis_tready = ready1;
	assign s_acc    = s_axis_tvalid && ready1;
	assign load1    = s_acc && !item.drop;

	rbf_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (s_acc),
		.cmd          (s_axis_tuser),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.item         (item),
		.addr         (rd_addr)
	);

	always_comb begin
		pix_in[CH_RED]   = s_axis_tdata[7:0];
		pix_in[CH_GREEN] = s_axis_tdata[15:8];
		pix_in[CH_BLUE]  = s_axis_tdata[23:16];
		if (item.zero_pix) begin
			pix_in = '0;
		end
	end

	// row store: upper in the high half, middle in the low half
	rbf_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (fire1),
		.waddr (addr_s1),
		.wdata ({mid, pix_s1}),
		.re    (load1),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign up  = fwd_s1 ? fwd_up_s1  : pix_t'(ram_rdata[2*PIX_W-1:PIX_W]);
	assign mid = fwd_s1 ? fwd_mid_s1 : pix_t'(ram_rdata[PIX_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1  <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (ready1) begin
				v1_s1 <= load1;
			end
			if (load1) begin
				fwd_s1 <= fire1 && (addr_s1 == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			pix_s1     <= pix_in;
			addr_s1    <= rd_addr;
			res_s1     <= item.has_result;
			inner_s1   <= item.inner;
			last_s1    <= item.last_px;
			fwd_up_s1  <= mid;
			fwd_mid_s1 <= pix_s1;
		end
	end

	// window kept as column sums: pair of the two older columns plus the newest
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			cs_new[c] = COL_W'(up[c]) + COL_W'(mid[c]) + COL_W'(pix_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
			csb_q  <= '0;
			midb_q <= '0;
		end else if (fire1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				pair_q[c] <= PAIR_W'(csb_q[c]) + PAIR_W'(cs_new[c]);
			end
			csb_q  <= cs_new;
			midb_q <= mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (ready2) begin
			v2_s2 <= v1_s1 && res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				sum_s2[c] <= SUM_W'(pair_q[c]) + SUM_W'(cs_new[c]);
			end
			ctr_s2   <= midb_q;
			inner_s2 <= inner_s1;
			last_s2  <= last_s1;
		end
	end

	// divide by nine through the reciprocal
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c] = PROD_W'(sum_s2[c]) * PROD_W'(RECIP_9);
			mean[c] = prod[c][RECIP_SH +: CH_W];
		end
	end

	assign out_pix = inner_s2 ? mean : ctr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			m_pix_q  <= out_pix;
			m_last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {m_pix_q[CH_BLUE], m_pix_q[CH_GREEN], m_pix_q[CH_RED]};

	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load1 |=> v1_s1)
		else $error("accepted pixel word lost before row store stage");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v2_s2))
		else $error("result word without a filter stage entry");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && !ready2 |=> v1_s1 && $stable(addr_s1) && $stable(fwd_s1))
		else $error("stalled row store stage changed");

endmodule

// File: dv/rgb_box_filter_3x3_test.sv
// Self-checking testbench for the RGB 3x3 box filter: whole frames, drains and register settings.
`timescale 1ns / 1ps
module rgb_box_filter_3x3_test
	import rbf_pkg::*;
();

	localparam int W_MAX       = 1024;
	localparam int H_MAX       = 1024;
	localparam int ROW_CAP     = 16'hFFFF;
	localparam int IDLE_PCT    = 37;
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic CMD_PIXEL = ~CMD_DRAIN;

	typedef struct packed {
		pix_t pix;
		logic last;
	} px_result_t;

	typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_FULL} pix_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // red_in, green_in, blue_in
	logic        s_axis_tuser;   // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;   // red_out, green_out, blue_out
	logic        m_axis_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rgb_box_filter_3x3 #(
		.MAX_WIDTH (W_MAX),
		.MAX_HEIGHT(H_MAX)
	) i_dut (.*);

	always #5 clk = ~clk;

	// filter state mirrored by the predictor
	logic [DIM_W-1:0] cfg_width  = 11'd640;
	logic [DIM_W-1:0] cfg_height = 11'd480;
	pix_t        upper_line[W_MAX] = '{default: '0};
	pix_t        middle_line[W_MAX] = '{default: '0};
	pix_t        win[3][3] = '{default: '{default: '0}};
	int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
	bit          in_frame_full = 1'b0;
	px_result_t  pending_px[$];

	bit          stall_en = 1'b0;
	int          err_count = 0;
	int          cycle_count = 0;
	int          pixel_words = 0;
	int          results_checked = 0;
	int          frame_count = 0;
	string       chan_name[NUM_CH] = '{"blue", "green", "red"};

	function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned cap);
		if (v == '0)
			return 1;
		return (v > cap) ? cap : v;
	endfunction

	function automatic void predict_word(logic cmd, pix_t din);
		int unsigned w, h, q, idx, sum;
		pix_t pix, up, mid, res;
		bit inner, last;
		w = eff_dim(cfg_width, W_MAX);
		h = eff_dim(cfg_height, H_MAX);
		if (!in_frame_full && cmd == CMD_DRAIN)
			return;
		pix = in_frame_full ? '0 : din;
		idx = (in_col < W_MAX) ? in_col : 0;
		up  = upper_line[idx];
		mid = middle_line[idx];
		upper_line[idx]  = mid;
		middle_line[idx] = pix;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = pix;
		q = in_row * w + in_col;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			if (in_row < ROW_CAP)
				in_row++;
			if (in_row >= h)
				in_frame_full = 1'b1;
		end
		if (q < w + 1)
			return;
		inner = w >= 3 && h >= 3 && out_row >= 1 && out_row + 2 <= h
			&& out_col >= 1 && out_col + 2 <= w;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (inner) begin
				sum = 0;
				for (int r = 0; r < 3; r++)
					for (int k = 0; k < 3; k++)
						sum += win[r][k][ch];
				res[ch] = CH_W'(sum / 9);
			end else begin
				res[ch] = win[1][1][ch];
			end
		end
		last = out_row + 1 >= h && out_col + 1 >= w;
		pending_px.push_back('{pix: res, last: last});
		if (last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			in_frame_full = 1'b0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				if (out_row < ROW_CAP)
					out_row++;
			end
		end
	endfunction

	function automatic pix_t gen_pix(pix_mode_t mode);
		pix_t p;
		p = pix_t'($urandom);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (mode == PIX_FULL)
				p[ch] = '1;
			else if (mode == PIX_EXTREME)
				p[ch] = $urandom_range(0, 1) ? '1 : '0;
		end
		return p;
	endfunction

	task automatic flag_mismatch(string what, int want, int got);
		err_count++;
		if (err_count <= 10)
			$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	task automatic send_word(logic cmd, pix_t pix);
		while (stall_en && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pix[CH_BLUE], pix[CH_GREEN], pix[CH_RED]};
		s_axis_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_word(cmd, pix);
		if (cmd == CMD_PIXEL)
			pixel_words++;
	endtask

	// only called between frames: wait for the last word, then let the pipe empty
	task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WIDTH)
			cfg_width = value;
		else
			cfg_height = value;
	endtask

	task automatic run_frame(logic [DIM_W-1:0] wv, logic [DIM_W-1:0] hv, pix_mode_t mode);
		int unsigned n;
		write_reg(REG_WIDTH, wv);
		write_reg(REG_HEIGHT, hv);
		n = eff_dim(wv, W_MAX) * eff_dim(hv, H_MAX);
		for (int unsigned i = 0; i < n; i++) begin
			// early drain: must be ignored
			if ($urandom_range(0, 99) < 4)
				send_word(CMD_DRAIN, pix_t'($urandom));
			send_word(CMD_PIXEL, gen_pix(mode));
		end
		// flush the tail; pixels sent now are taken as drains
		while (in_col || in_row || out_col || out_row || in_frame_full)
			send_word($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_DRAIN, pix_t'($urandom));
		repeat ($urandom_range(0, 2))
			send_word(CMD_DRAIN, pix_t'($urandom));
		frame_count++;
	endtask

	task automatic test_directed();
		stall_en = 1'b0;
		send_word(CMD_DRAIN, '1);
		run_frame(11'd3, 11'd3, PIX_FULL);
		run_frame(11'd3, 11'd3, PIX_EXTREME);
	endtask

	task automatic test_random_frames();
		int stop_at, calm_until;
		logic [DIM_W-1:0] wv, hv;
		int pick;
		stop_at    = pixel_words + 700;
		calm_until = pixel_words + 250;
		while (pixel_words < stop_at) begin
			stall_en = pixel_words >= calm_until;
			pick = $urandom_range(0, 99);
			if (pick < 85)
				wv = DIM_W'($urandom_range(1, 16));
			else if (pick < 95)
				wv = DIM_W'($urandom_range(17, 64));
			else
				wv = '0;
			hv = DIM_W'($urandom_range(0, 12));
			run_frame(wv, hv, pix_mode_t'($urandom_range(0, 7) == 0 ? PIX_EXTREME : PIX_RANDOM));
		end
	endtask

	task automatic test_small_dims();
		stall_en = 1'b1;
		for (int wv = 0; wv <= 3; wv++)
			for (int hv = 0; hv <= 3; hv++)
				run_frame(DIM_W'(wv), DIM_W'(hv),
					pix_mode_t'($urandom_range(0, 1) ? PIX_EXTREME : PIX_RANDOM));
	endtask

	task automatic test_large_dims();
		stall_en = 1'b1;
		run_frame(11'd1, 11'd2047, PIX_RANDOM);
	endtask

	always @(posedge clk)
		m_axis_tready <= !(stall_en && $urandom_range(0, 99) < IDLE_PCT);

	always @(posedge clk) begin
		pix_t got;
		px_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got[CH_RED]   = m_axis_tdata[7:0];
			got[CH_GREEN] = m_axis_tdata[15:8];
			got[CH_BLUE]  = m_axis_tdata[23:16];
			if (pending_px.size() == 0) begin
				flag_mismatch("word with nothing pending", -1, m_axis_tdata);
			end else begin
				want = pending_px.pop_front();
				for (int ch = 0; ch < NUM_CH; ch++)
					if (got[ch] !== want.pix[ch])
						flag_mismatch(chan_name[ch], want.pix[ch], got[ch]);
				if (m_axis_tlast !== want.last)
					flag_mismatch("last_of_frame", want.last, m_axis_tlast);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, pending_px.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_PIXEL;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames();
		test_small_dims();
		test_large_dims();

		s_axis_tvalid <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE * 4) @(posedge clk);
		$display("%0d frames, %0d pixel words in, %0d filtered words checked",
			frame_count, pixel_words, results_checked);
		$display("sizes from 1x1 up to 64 wide and 1024 tall, incl. zero and saturating registers");
		if (err_count == 0 && pending_px.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
rtl/core/rbf_pkg.sv
rtl/core/rbf_ram.sv
rtl/core/rbf_ctrl.sv
rtl/core/rgb_box_filter_3x3.sv
dv/rgb_box_filter_3x3_test.sv
